// ===== design/pfair_pkg.sv =====
// shared types, constants and helpers for the playfair digraph cipher
package pfair_pkg;

  localparam int SIDE      = 5;
  localparam int LETTER_W  = 5;
  localparam int POS_W     = 3;
  localparam int ROW_W     = SIDE * LETTER_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] LETTER_X = LETTER_W'(23);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROW4 = CFG_IDX_W'(4);

  typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

  // plain alphabet without j, row major
  localparam square_t SQUARE_RESET = {
    ROW_W'(27025109), ROW_W'(21613104), ROW_W'(16201099),
    ROW_W'(10755269), ROW_W'(4294688)
  };

  typedef struct packed {
    logic                action;
    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
    logic                second_present;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_first;
    logic [LETTER_W-1:0] out_second;
    logic                not_found;
  } out_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  // one place forward (encrypt) or back (decrypt), wrapping at the side
  function automatic logic [POS_W-1:0] wrap_step(input logic [POS_W-1:0] idx,
                                                 input logic decrypt);
    logic [POS_W-1:0] res;
    res = '0;
    if (decrypt) begin
      res = (idx == '0) ? POS_W'(SIDE - 1) : idx - POS_W'(1);
    end else begin
      res = (idx == POS_W'(SIDE - 1)) ? '0 : idx + POS_W'(1);
    end
    return res;
  endfunction

  function automatic logic [LETTER_W-1:0] cell_at(input square_t sq,
                                                  input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    logic [ROW_W-1:0] row;
    row = sq[r];
    return row[c * LETTER_W +: LETTER_W];
  endfunction

endpackage

// ===== design/pfair_locate.sv =====
// finds one letter in the key square, last match in row-major order wins
module pfair_locate
  import pfair_pkg::*;
(
  input  square_t             square,
  input  logic [LETTER_W-1:0] letter,
  output pos_t                pos
);

  logic [SIDE-1:0][SIDE-1:0] hit;
  logic [SIDE-1:0]           row_hit;
  logic [SIDE-1:0]           sel_hits;
  logic [POS_W-1:0]          row_sel;
  logic [POS_W-1:0]          col_sel;

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        hit[r][c] = (square[r][c * LETTER_W +: LETTER_W] == letter);
      end
      row_hit[r] = |hit[r];
    end
  end

  // highest row with a hit, then highest column within it
  always_comb begin
    row_sel = '0;
    for (int r = 0; r < SIDE; r++) begin
      if (row_hit[r]) begin
        row_sel = POS_W'(r);
      end
    end
    sel_hits = hit[row_sel];
    col_sel  = '0;
    for (int c = 0; c < SIDE; c++) begin
      if (sel_hits[c]) begin
        col_sel = POS_W'(c);
      end
    end
  end

  assign pos.found = |row_hit;
  assign pos.row   = row_sel;
  assign pos.col   = col_sel;

endmodule

// ===== design/pfair_subst.sv =====
// digraph substitution: same row, same column or rectangle swap
module pfair_subst
  import pfair_pkg::*;
(
  input  square_t   square,
  input  logic      decrypt,
  input  pos_t      pos1,
  input  pos_t      pos2,
  output out_item_t result
);

  logic [POS_W-1:0] r1, c1, r2, c2;

  always_comb begin
    r1 = pos1.row;
    c1 = pos2.col;
    r2 = pos2.row;
    c2 = pos1.col;
    if (pos1.row == pos2.row) begin
      r1 = pos1.row;
      r2 = pos2.row;
      c1 = wrap_step(pos1.col, decrypt);
      c2 = wrap_step(pos2.col, decrypt);
    end else if (pos1.col == pos2.col) begin
      r1 = wrap_step(pos1.row, decrypt);
      r2 = wrap_step(pos2.row, decrypt);
      c1 = pos1.col;
      c2 = pos2.col;
    end
  end

  always_comb begin
    if (pos1.found && pos2.found) begin
      result.out_first  = cell_at(square, r1, c1);
      result.out_second = cell_at(square, r2, c2);
      result.not_found  = 1'b0;
    end else begin
      result.out_first  = '0;
      result.out_second = '0;
      result.not_found  = 1'b1;
    end
  end

endmodule

// ===== design/playfair_digraph_cipher.sv =====
// top level of the playfair digraph cipher
//
// input channel: in_valid/in_ready with in_data, one letter pair and a mode
// bit per transfer. result channel: out_valid/out_ready with out_data, one
// result per pair, in order. configuration channel: cfg_valid/cfg_ready
// writes key square row cfg_index with cfg_data; indexes past the last row
// are taken and ignored. cfg_ready is always high; write only while idle.
//
// a pair is latched in the input register, located and substituted by
// compare and mux logic, and lands in the result register, from which
// out_valid is driven. one pair per cycle is taken and delivered while
// out_ready stays high; both letters are located in parallel, each against
// the 25 cells, in the compare logic between the two registers.
//
// when out_ready is low the result register holds, the input register holds
// its pair behind it, and in_ready drops once both are full.
// reset (rst_n low, synchronous) empties both registers and loads the
// plain alphabet square without j.
module playfair_digraph_cipher
  import pfair_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  square_t   square_r;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;

  logic                out_load;
  logic                in_load;
  logic [LETTER_W-1:0] letter_a;
  logic [LETTER_W-1:0] letter_b;
  pos_t                pos1;
  pos_t                pos2;
  out_item_t           result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r <= SQUARE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW0: square_r[0] <= cfg_data;
        REG_ROW1: square_r[1] <= cfg_data;
        REG_ROW2: square_r[2] <= cfg_data;
        REG_ROW3: square_r[3] <= cfg_data;
        REG_ROW4: square_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_load = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || out_load;
  assign in_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item_r <= in_data;
    end
  end

  // x pads a missing second letter, j is searched as i
  always_comb begin
    letter_a = in_item_r.first_letter;
    letter_b = in_item_r.second_present ? in_item_r.second_letter : LETTER_X;
    if (letter_a == LETTER_J) begin
      letter_a = LETTER_I;
    end
    if (letter_b == LETTER_J) begin
      letter_b = LETTER_I;
    end
  end

  pfair_locate u_locate_a (
    .square (square_r),
    .letter (letter_a),
    .pos    (pos1)
  );

  pfair_locate u_locate_b (
    .square (square_r),
    .letter (letter_b),
    .pos    (pos2)
  );

  pfair_subst u_subst (
    .square  (square_r),
    .decrypt (in_item_r.action),
    .pos1    (pos1),
    .pos2    (pos2),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.not_found |->
      out_item_r.out_first == '0 && out_item_r.out_second == '0)
    else $error("not_found result carries nonzero letters");

  a_pair_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("pair left input register without reaching result register");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while result register is empty");

  a_held_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_load |=> in_valid_r && $stable(in_item_r))
    else $error("stalled pair lost from input register");

endmodule

// ===== tb/playfair_digraph_cipher_test.sv =====
// testbench for playfair_digraph_cipher: random squares and pairs against a predictor
module playfair_digraph_cipher_test;
  import pfair_pkg::*;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  localparam int SQ_PLAIN = 0;
  localparam int SQ_PERM  = 1;
  localparam int SQ_DUPS  = 2;
  localparam int SQ_NOISE = 3;
  localparam int SQ_ZERO  = 4;
  localparam int SQ_ONES  = 5;

  localparam int  NUM_BLOCKS      = 12;
  localparam int  PAIRS_PER_BLOCK = 140;
  localparam int  HOLD_CYCLES     = 60;
  localparam longint CYCLE_LIMIT  = 200000;

  localparam logic [CFG_IDX_W-1:0] ROW_REG [SIDE] =
    '{REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3, REG_ROW4};

  // predictor of the cipher plus the queue of results still owed by the block
  class pair_codebook;
    logic [ROW_W-1:0] rows [SIDE];
    out_item_t        owed [$];
    int errors;
    int checked;
    int n_row, n_col, n_rect, n_absent;

    function new();
      foreach (rows[r]) rows[r] = SQUARE_RESET[r];
      errors = 0;
      checked = 0;
      n_row = 0;
      n_col = 0;
      n_rect = 0;
      n_absent = 0;
    endfunction

    function void set_row(input int r, input logic [ROW_W-1:0] val);
      rows[r] = val;
    endfunction

    function logic [LETTER_W-1:0] entry(input int r, input int c);
      return rows[r][c*LETTER_W +: LETTER_W];
    endfunction

    // last match in row-major order wins
    function bit find(input logic [LETTER_W-1:0] l, output int fr, output int fc);
      bit hit;
      hit = 1'b0;
      fr = 0;
      fc = 0;
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE; c++) begin
          if (entry(r, c) == l) begin
            fr = r;
            fc = c;
            hit = 1'b1;
          end
        end
      end
      return hit;
    endfunction

    function out_item_t substitute(input in_item_t it);
      logic [LETTER_W-1:0] a, b;
      int r1, c1, r2, c2, step;
      bit f1, f2;
      out_item_t res;
      a = it.first_letter;
      b = it.second_present ? it.second_letter : LETTER_X;
      if (a == LETTER_J) a = LETTER_I;
      if (b == LETTER_J) b = LETTER_I;
      f1 = find(a, r1, c1);
      f2 = find(b, r2, c2);
      step = (it.action == ACT_DECRYPT) ? SIDE - 1 : 1;
      res = '0;
      if (!f1 || !f2) begin
        res.not_found = 1'b1;
        n_absent++;
      end else if (r1 == r2) begin
        res.out_first  = entry(r1, (c1 + step) % SIDE);
        res.out_second = entry(r2, (c2 + step) % SIDE);
        n_row++;
      end else if (c1 == c2) begin
        res.out_first  = entry((r1 + step) % SIDE, c1);
        res.out_second = entry((r2 + step) % SIDE, c2);
        n_col++;
      end else begin
        res.out_first  = entry(r1, c2);
        res.out_second = entry(r2, c1);
        n_rect++;
      end
      return res;
    endfunction

    function void note_pair(input in_item_t it);
      owed.push_back(substitute(it));
    endfunction

    function void check_result(input out_item_t got);
      out_item_t exp_r;
      if (owed.size() == 0) begin
        $error("result transfer with no pair outstanding: %p", got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      checked++;
      if (got.out_first !== exp_r.out_first) begin
        $error("out_first: expected %0d, got %0d", exp_r.out_first, got.out_first);
        errors++;
      end
      if (got.out_second !== exp_r.out_second) begin
        $error("out_second: expected %0d, got %0d", exp_r.out_second, got.out_second);
        errors++;
      end
      if (got.not_found !== exp_r.not_found) begin
        $error("not_found: expected %0d, got %0d", exp_r.not_found, got.not_found);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;

  pair_codebook codebook = new();
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     squares_loaded = 0;
  logic   hold_toggle = 1'b0;
  logic   hold_seen = 1'b0;
  int     hold_left = 0;
  longint cycle_count = 0;

  playfair_digraph_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transfer, then pick out_ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) codebook.check_result(out_data);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t mk_pair(input logic act, input int a, input int b,
                                       input logic present);
    in_item_t it;
    it.action         = act;
    it.first_letter   = LETTER_W'(a);
    it.second_letter  = LETTER_W'(b);
    it.second_present = present;
    return it;
  endfunction

  function automatic square_t make_square(input int kind);
    logic [LETTER_W-1:0] pool [26];
    logic [LETTER_W-1:0] t;
    square_t sq;
    int j;
    for (int i = 0; i < 26; i++) pool[i] = LETTER_W'(i);
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    sq = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        case (kind)
          SQ_PLAIN: sq[r][c*LETTER_W +: LETTER_W] = SQUARE_RESET[r][c*LETTER_W +: LETTER_W];
          SQ_NOISE: sq[r][c*LETTER_W +: LETTER_W] = LETTER_W'($urandom_range(31));
          SQ_ZERO:  sq[r][c*LETTER_W +: LETTER_W] = '0;
          SQ_ONES:  sq[r][c*LETTER_W +: LETTER_W] = '1;
          default:  sq[r][c*LETTER_W +: LETTER_W] = pool[r*SIDE + c];
        endcase
      end
    end
    // copy a few cells over others so letters repeat
    if (kind == SQ_DUPS) begin
      for (int k = 0; k < 4; k++) begin
        j = $urandom_range(SIDE*SIDE - 1);
        t = sq[j / SIDE][(j % SIDE)*LETTER_W +: LETTER_W];
        j = $urandom_range(SIDE*SIDE - 1);
        sq[j / SIDE][(j % SIDE)*LETTER_W +: LETTER_W] = t;
      end
    end
    return sq;
  endfunction

  // mostly pairs drawn from the current square, so every rule is reached
  function automatic in_item_t rand_pair();
    int pick, r1, c1, r2, c2;
    logic act;
    act = 1'($urandom_range(1));
    pick = $urandom_range(99);
    r1 = $urandom_range(SIDE - 1);
    c1 = $urandom_range(SIDE - 1);
    r2 = $urandom_range(SIDE - 1);
    c2 = $urandom_range(SIDE - 1);
    if (pick < 25) begin
      return mk_pair(act, int'(codebook.entry(r1, c1)), int'(codebook.entry(r1, c2)), 1'b1);
    end else if (pick < 50) begin
      return mk_pair(act, int'(codebook.entry(r1, c1)), int'(codebook.entry(r2, c1)), 1'b1);
    end else if (pick < 75) begin
      return mk_pair(act, int'(codebook.entry(r1, c1)), int'(codebook.entry(r2, c2)), 1'b1);
    end else if (pick < 82) begin
      return mk_pair(act, int'(codebook.entry(r1, c1)), $urandom_range(31), 1'b0);
    end else if (pick < 90) begin
      if ($urandom_range(1))
        return mk_pair(act, int'(LETTER_J), int'(codebook.entry(r2, c2)), 1'b1);
      return mk_pair(act, int'(codebook.entry(r1, c1)), int'(LETTER_J), 1'b1);
    end
    return mk_pair(act, $urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
  endfunction

  task automatic wait_drained();
    while (codebook.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_square(input square_t sq);
    wait_drained();
    for (int r = 0; r < SIDE; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ROW_REG[r];
      cfg_data  <= sq[r];
      do @(posedge clk); while (!cfg_ready);
      codebook.set_row(r, sq[r]);
    end
    cfg_valid <= 1'b0;
    squares_loaded++;
  endtask

  // called at the edge of the previous transfer, or while in_valid is low
  task automatic send_pair(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    codebook.note_pair(it);
  endtask

  initial begin
    in_item_t directed [$];
    int kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset square: wraps, columns, rectangles, j, padding, absent letters
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, 1, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 0, 1, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 3, 4, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 0, 4, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, 21, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 0, 21, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, 25, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 25, 0, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, int'(LETTER_J), 0, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, int'(LETTER_J), 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, int'(LETTER_J), int'(LETTER_J), 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 2, 2, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, 31, 1'b0));
    directed.push_back(mk_pair(ACT_DECRYPT, int'(LETTER_X), 5, 1'b0));
    directed.push_back(mk_pair(ACT_ENCRYPT, 26, 0, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 0, 31, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 31, 31, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 0, 0, 1'b1));
    directed.push_back(mk_pair(ACT_DECRYPT, 25, 25, 1'b1));
    directed.push_back(mk_pair(ACT_ENCRYPT, 25, 0, 1'b0));
    directed.push_back(mk_pair(ACT_DECRYPT, 0, 31, 1'b0));
    directed.push_back(mk_pair(ACT_ENCRYPT, 7, 15, 1'b1));
    foreach (directed[i]) send_pair(directed[i]);
    in_valid <= 1'b0;

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      if (blk == 3)       kind = SQ_ZERO;
      else if (blk == 7)  kind = SQ_ONES;
      else if (blk == 11) kind = SQ_PLAIN;
      else if (blk % 3 == 0) kind = SQ_NOISE;
      else if (blk % 3 == 1) kind = SQ_PERM;
      else kind = SQ_DUPS;
      load_square(make_square(kind));

      if (blk < 4) begin
        send_idle_pct = 21;
        recv_idle_pct = 82;
      end else if (blk < 8) begin
        send_idle_pct = 82;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result stall while pairs keep coming, so in_ready drops
      if (blk == 8) hold_toggle <= ~hold_toggle;

      for (int n = 0; n < PAIRS_PER_BLOCK; n++) send_pair(rand_pair());
      in_valid <= 1'b0;
    end

    wait_drained();
    $display("checked %0d results over %0d key squares", codebook.checked, squares_loaded);
    $display("same row %0d, same column %0d, rectangle %0d, letter absent %0d",
             codebook.n_row, codebook.n_col, codebook.n_rect, codebook.n_absent);
    if (codebook.errors == 0 && codebook.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
